// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks in the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Check that cons follows ante, with the delay given by the argument n.
`define ASSERT_LATENCY(name, clk, rst, ante, cons, n) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("latency check failed");

`endif

// ===== sv/sva_pkg.sv =====
// ---------------------------------------------------------------------------
// Sound voice allocator package
// Widths, reset values and constants of the voice allocator.
// ---------------------------------------------------------------------------
package sva_pkg;

   // Voice pool size
   localparam int DEFAULT_VOICES = 8;

   // Field widths
   localparam int ID_W     = 8;
   localparam int VOL_W    = 7;
   localparam int SEP_W    = 8;
   localparam int TICK_W   = 32;
   localparam int VOICE_W  = 3;
   localparam int HANDLE_W = 16;
   localparam int PAN_W    = 8;

   // Configuration space: six single-instance id registers
   localparam int NUM_SINGLE = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [ID_W-1:0] SINGLE_RESET [NUM_SINGLE] =
      '{8'd10, 8'd11, 8'd12, 8'd13, 8'd22, 8'd1};

   // Handle restarts here after the counter wraps to zero
   localparam logic [HANDLE_W-1:0] HANDLE_RESTART = 16'd100;

   // Volume: scale by four, clamp to the mixer maximum
   localparam logic [VOL_W-1:0] VOL_MAX       = 7'd64;
   localparam logic [VOL_W-1:0] VOL_CLAMP_MIN = 7'd17;

   // Pan center
   localparam logic [SEP_W:0] SEP_CENTER = 9'd128;

endpackage

// ===== sv/sound_voice_allocator.sv =====
// A request taken at a clock edge passes the input register, then the result register, to its result strobe.
// Throughput: one request per cycle; busy stays low and the receiver cannot stall.
// Voice choice, freeing and oldest search run as one parallel compare stage.
// Reset clears all voices to inactive, the handle counter to zero and the
// single-instance id registers to their defaults.
// ---------------------------------------------------------------------------
// Sound voice allocator
// Assigns a mixer voice per sound start, stealing the oldest voice when full.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sound_voice_allocator
   import sva_pkg::*;
#(
   parameter int VOICES = DEFAULT_VOICES
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       start,
   output logic                       busy,
   input  logic [ID_W-1:0]            req_sound_id,
   input  logic [VOL_W-1:0]           req_volume,
   input  logic [SEP_W-1:0]           req_separation,
   input  logic [TICK_W-1:0]          req_now_tick,
   // result channel
   output logic                       rsp_valid,
   output logic [VOICE_W-1:0]         rsp_voice,
   output logic [HANDLE_W-1:0]        rsp_handle,
   output logic [VOL_W-1:0]           rsp_mix_volume,
   output logic signed [PAN_W-1:0]    rsp_mix_pan,
   output logic                       rsp_stolen,
   // configuration port
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [CSR_DATA_W-1:0]      csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   localparam int IDX_W = $clog2(VOICES);

   // Configuration registers
   logic [ID_W-1:0]       single_id_ff [NUM_SINGLE];
   logic [CSR_IDX_W-1:0]  csr_idx;
   logic                  csr_wr;

   // Input register
   logic                  req_valid_ff;
   logic [ID_W-1:0]       id_ff;
   logic [VOL_W-1:0]      vol_ff;
   logic [SEP_W-1:0]      sep_ff;
   logic [TICK_W-1:0]     now_ff;

   // Voice state
   logic [VOICES-1:0]     active_ff;
   logic [VOICES-1:0]     active_in;
   logic [TICK_W-1:0]     tick_ff [VOICES];
   logic [ID_W-1:0]       sid_ff  [VOICES];
   logic [HANDLE_W-1:0]   handle_cnt_ff;
   logic [HANDLE_W-1:0]   handle_cnt_in;
   logic [HANDLE_W-1:0]   handle_issue;

   // Allocation logic
   logic                  single_hit;
   logic [VOICES-1:0]     id_match;
   logic [VOICES-1:0]     kill_oh;
   logic [VOICES-1:0]     act_now;
   logic [VOICES-1:0]     free_vec;
   logic [VOICES-1:0]     free_low;
   logic [VOICES-1:0]     older;
   logic [VOICES-1:0]     win_oh;
   logic [VOICES-1:0]     steal_oh;
   logic [VOICES-1:0]     pick_oh;
   logic                  any_free;
   logic [IDX_W-1:0]      pick_idx;

   // Result shaping
   logic [VOL_W-1:0]      mix_vol;
   logic signed [SEP_W:0] sep_diff;
   logic signed [SEP_W:0] sep_adj;
   logic signed [SEP_W:0] pan_wide;

   // Result register
   logic                  rsp_valid_ff;
   logic [IDX_W-1:0]      rsp_idx_ff;
   logic [HANDLE_W-1:0]   rsp_handle_ff;
   logic [VOL_W-1:0]      rsp_vol_ff;
   logic [PAN_W-1:0]      rsp_pan_ff;
   logic                  rsp_stolen_ff;
   logic [IDX_W+VOICE_W-1:0] voice_wide;

   // ------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Write a single-instance id; drop writes beyond the register list
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_SINGLE; k++) begin
            single_id_ff[k] <= SINGLE_RESET[k];
         end
      end else if (csr_wr && (csr_idx < CSR_IDX_W'(NUM_SINGLE))) begin
         single_id_ff[csr_idx] <= csr_pwdata[ID_W-1:0];
      end
   end

   // Read back the addressed register
   always_comb begin
      csr_prdata = '0;
      if (csr_idx < CSR_IDX_W'(NUM_SINGLE)) begin
         csr_prdata[ID_W-1:0] = single_id_ff[csr_idx];
      end
   end

   // ------------------------------------------------------------------
   // Input register
   // ------------------------------------------------------------------
   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         id_ff  <= req_sound_id;
         vol_ff <= req_volume;
         sep_ff <= req_separation;
         now_ff <= req_now_tick;
      end
   end

   // ------------------------------------------------------------------
   // Voice selection
   // ------------------------------------------------------------------

   // Match the id against the single-instance list
   always_comb begin
      single_hit = 1'b0;
      for (int k = 0; k < NUM_SINGLE; k++) begin
         if (single_id_ff[k] == id_ff) begin
            single_hit = 1'b1;
         end
      end
   end

   // Free the lowest active voice playing the same single-instance id
   always_comb begin
      for (int v = 0; v < VOICES; v++) begin
         id_match[v] = active_ff[v] & (sid_ff[v] == id_ff);
         older[v]    = tick_ff[v] < now_ff;
      end
   end

   assign kill_oh  = single_hit ? (id_match & (~id_match + 1'b1)) : '0;
   assign act_now  = active_ff & ~kill_oh;
   assign free_vec = ~act_now;
   assign free_low = free_vec & (~free_vec + 1'b1);
   assign any_free = |free_vec;

   // Oldest voice: started before now, lowest index on equal ticks
   always_comb begin
      for (int i = 0; i < VOICES; i++) begin
         win_oh[i] = older[i];
         for (int j = 0; j < VOICES; j++) begin
            if (j < i) begin
               if (older[j] && !(tick_ff[i] < tick_ff[j])) begin
                  win_oh[i] = 1'b0;
               end
            end else if (j > i) begin
               if (older[j] && (tick_ff[j] < tick_ff[i])) begin
                  win_oh[i] = 1'b0;
               end
            end
         end
      end
   end

   // Fall back to voice 0 when no voice is older than now
   assign steal_oh = (|win_oh) ? win_oh : VOICES'(1);
   assign pick_oh  = any_free ? free_low : steal_oh;

   always_comb begin
      pick_idx = '0;
      for (int v = 0; v < VOICES; v++) begin
         if (pick_oh[v]) begin
            pick_idx = pick_idx | IDX_W'(v);
         end
      end
   end

   assign active_in = act_now | pick_oh;

   // Advance the voice activity
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (req_valid_ff) begin
         active_ff <= active_in;
      end
   end

   // Record tick and id of the chosen voice
   always_ff @(posedge clock) begin
      for (int v = 0; v < VOICES; v++) begin
         if (req_valid_ff && pick_oh[v]) begin
            tick_ff[v] <= now_ff;
            sid_ff[v]  <= id_ff;
         end
      end
   end

   // ------------------------------------------------------------------
   // Handle counter
   // ------------------------------------------------------------------
   assign handle_issue  = (handle_cnt_ff == '0) ? HANDLE_RESTART : handle_cnt_ff;
   assign handle_cnt_in = handle_issue + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         handle_cnt_ff <= '0;
      end else if (req_valid_ff) begin
         handle_cnt_ff <= handle_cnt_in;
      end
   end

   // ------------------------------------------------------------------
   // Volume and pan
   // ------------------------------------------------------------------
   assign mix_vol = (vol_ff >= VOL_CLAMP_MIN) ? VOL_MAX : {vol_ff[VOL_W-3:0], 2'b00};

   // Halve toward zero; the result always lies within the pan range
   assign sep_diff = $signed({1'b0, sep_ff} - SEP_CENTER);
   assign sep_adj  = sep_diff + $signed({{SEP_W{1'b0}}, sep_diff[SEP_W]});
   assign pan_wide = sep_adj >>> 1;

   // ------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_idx_ff    <= pick_idx;
         rsp_handle_ff <= handle_issue;
         rsp_vol_ff    <= mix_vol;
         rsp_pan_ff    <= pan_wide[PAN_W-1:0];
         rsp_stolen_ff <= ~any_free;
      end
   end

   assign voice_wide     = {{VOICE_W{1'b0}}, rsp_idx_ff};
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_voice      = voice_wide[VOICE_W-1:0];
   assign rsp_handle     = rsp_handle_ff;
   assign rsp_mix_volume = rsp_vol_ff;
   assign rsp_mix_pan    = $signed(rsp_pan_ff);
   assign rsp_stolen     = rsp_stolen_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `ASSERT_LATENCY(a_req_to_rsp, clock, reset, start && !busy, rsp_valid, 2)
   `ASSERT_IMPLY(a_handle_range, clock, reset, rsp_valid, rsp_handle >= HANDLE_RESTART)
   `ASSERT_IMPLY(a_voice_active, clock, reset, rsp_valid, active_ff[rsp_idx_ff])
   `ASSERT_IMPLY(a_volume_max, clock, reset, rsp_valid, rsp_mix_volume <= VOL_MAX)

endmodule

// ===== tb/sound_voice_allocator_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sound voice allocator checker
// Watches request, result and register transfers, predicts the voice grant
// for every accepted request and compares each result field against it.
// ---------------------------------------------------------------------------
module sound_voice_allocator_checker
   import sva_pkg::*;
#(
   parameter int VOICES = DEFAULT_VOICES
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  logic [ID_W-1:0]         req_sound_id,
   input  logic [VOL_W-1:0]        req_volume,
   input  logic [SEP_W-1:0]        req_separation,
   input  logic [TICK_W-1:0]       req_now_tick,
   input  logic                    rsp_valid,
   input  logic [VOICE_W-1:0]      rsp_voice,
   input  logic [HANDLE_W-1:0]     rsp_handle,
   input  logic [VOL_W-1:0]        rsp_mix_volume,
   input  logic signed [PAN_W-1:0] rsp_mix_pan,
   input  logic                    rsp_stolen,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   input  logic [CSR_DATA_W-1:0]   csr_prdata,
   input  logic                    csr_pready,
   output int                      mismatch_count,
   output int                      grants_pending
);

   localparam int PAN_LIMIT = 64;
   localparam int VOL_SCALE = 4;

   typedef struct packed {
      logic [VOICE_W-1:0]     voice;
      logic [HANDLE_W-1:0]    handle;
      logic [VOL_W-1:0]       mix_volume;
      logic signed [PAN_W-1:0] mix_pan;
      logic                   stolen;
   } voice_grant_type;

   // Predicted grants, oldest first
   voice_grant_type expected_grants [$];

   // Mirror of the allocator state
   logic [ID_W-1:0]   solo_ids   [NUM_SINGLE];
   logic              chan_active [VOICES];
   logic [TICK_W-1:0] chan_tick   [VOICES];
   logic [ID_W-1:0]   chan_sound  [VOICES];
   logic [HANDLE_W-1:0] handle_next;
   int                mismatches;

   initial begin
      mismatch_count = 0;
      grants_pending = 0;
      mismatches     = 0;
   end

   // Free, pick or steal a voice and build the grant it yields
   function automatic voice_grant_type allocate_voice(input logic [ID_W-1:0]   id,
                                                      input logic [VOL_W-1:0]  vol,
                                                      input logic [SEP_W-1:0]  sep,
                                                      input logic [TICK_W-1:0] now);
      voice_grant_type   g;
      logic              solo;
      logic              freed;
      int                slot;
      int                oldest_idx;
      logic [TICK_W-1:0] oldest;
      int                scaled;
      int                pan;
      int                k;
      int                v;

      solo = 1'b0;
      for (k = 0; k < NUM_SINGLE; k++) begin
         if (solo_ids[k] == id) solo = 1'b1;
      end

      // Drop the first voice already playing this id when it is a single-instance id
      freed = 1'b0;
      if (solo) begin
         for (v = 0; v < VOICES; v++) begin
            if (!freed && chan_active[v] && chan_sound[v] == id) begin
               chan_active[v] = 1'b0;
               freed = 1'b1;
            end
         end
      end

      // Lowest free voice; track the oldest one scanned on the way
      slot       = -1;
      oldest     = now;
      oldest_idx = 0;
      for (v = 0; v < VOICES; v++) begin
         if (slot < 0) begin
            if (!chan_active[v]) begin
               slot = v;
            end else if (chan_tick[v] < oldest) begin
               oldest     = chan_tick[v];
               oldest_idx = v;
            end
         end
      end
      g.stolen = (slot < 0);
      if (slot < 0) slot = oldest_idx;

      chan_active[slot] = 1'b1;
      chan_tick[slot]   = now;
      chan_sound[slot]  = id;
      g.voice           = slot[VOICE_W-1:0];

      // Issue the handle; zero restarts at the restart value
      if (handle_next == '0) handle_next = HANDLE_RESTART;
      g.handle    = handle_next;
      handle_next = handle_next + 1'b1;

      scaled = int'(vol) * VOL_SCALE;
      if (scaled > int'(VOL_MAX)) scaled = int'(VOL_MAX);
      g.mix_volume = scaled[VOL_W-1:0];

      pan = (int'(sep) - int'(SEP_CENTER)) / 2;
      if (pan < -PAN_LIMIT) pan = -PAN_LIMIT;
      if (pan > PAN_LIMIT) pan = PAN_LIMIT;
      g.mix_pan = pan[PAN_W-1:0];
      return g;
   endfunction

   task automatic compare_field(input string field, input int want, input int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      voice_grant_type      want;
      logic [CSR_IDX_W-1:0] idx;

      if (reset) begin
         for (int k = 0; k < NUM_SINGLE; k++) solo_ids[k] = SINGLE_RESET[k];
         for (int v = 0; v < VOICES; v++) begin
            chan_active[v] = 1'b0;
            chan_tick[v]   = '0;
            chan_sound[v]  = '0;
         end
         handle_next = '0;
         expected_grants.delete();
      end else begin
         // Register transfers
         idx = csr_paddr[CSR_ADDR_W-1:2];
         if (csr_psel && csr_penable && csr_pready && int'(idx) < NUM_SINGLE) begin
            if (csr_pwrite)
               solo_ids[idx] = csr_pwdata[ID_W-1:0];
            else
               compare_field("register read", int'(solo_ids[idx]), int'(csr_prdata));
         end

         // Predict on the request transfer
         if (start && !busy)
            expected_grants.push_back(allocate_voice(req_sound_id, req_volume,
                                                     req_separation, req_now_tick));

         // Compare the result transfer with the oldest prediction
         if (rsp_valid) begin
            if (expected_grants.size() == 0) begin
               mismatches++;
               $display("%0t: result with no request pending, expected none, actual voice %0d handle %0d",
                        $time, rsp_voice, rsp_handle);
            end else begin
               want = expected_grants.pop_front();
               compare_field("voice", int'(want.voice), int'(rsp_voice));
               compare_field("handle", int'(want.handle), int'(rsp_handle));
               compare_field("mix_volume", int'(want.mix_volume), int'(rsp_mix_volume));
               compare_field("mix_pan", int'($signed(want.mix_pan)), int'(rsp_mix_pan));
               compare_field("stolen", int'(want.stolen), int'(rsp_stolen));
            end
         end
      end
      mismatch_count <= mismatches;
      grants_pending <= expected_grants.size();
   end

endmodule

// ===== tb/sound_voice_allocator_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sound voice allocator testbench
// Drives sound-start requests and single-instance id settings through
// directed and random phases; the checker judges every grant.
// ---------------------------------------------------------------------------
module sound_voice_allocator_tb;
   import sva_pkg::*;

   localparam int CLK_HALF      = 5;
   localparam int RESET_CYCLES  = 6;
   localparam int PHASES        = 5;
   localparam int PHASE_ITEMS   = 350;
   localparam int IDLE_PCT      = 24;
   localparam int DRAIN_CYCLES  = 8;
   localparam longint TIMEOUT_NS = 5_000_000;

   typedef enum int {
      REG_SINGLE_A, REG_SINGLE_B, REG_SINGLE_C, REG_SINGLE_D,
      REG_SINGLE_E, REG_SINGLE_F, REG_SPARE_6, REG_SPARE_7
   } csr_index_type;

   logic                    clock          = 1'b0;
   logic                    reset          = 1'b1;
   logic                    start          = 1'b0;
   logic                    busy;
   logic [ID_W-1:0]         req_sound_id   = '0;
   logic [VOL_W-1:0]        req_volume     = '0;
   logic [SEP_W-1:0]        req_separation = '0;
   logic [TICK_W-1:0]       req_now_tick   = '0;
   logic                    rsp_valid;
   logic [VOICE_W-1:0]      rsp_voice;
   logic [HANDLE_W-1:0]     rsp_handle;
   logic [VOL_W-1:0]        rsp_mix_volume;
   logic signed [PAN_W-1:0] rsp_mix_pan;
   logic                    rsp_stolen;
   logic                    csr_psel       = 1'b0;
   logic                    csr_penable    = 1'b0;
   logic                    csr_pwrite     = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr      = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata     = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;
   int                      mismatch_count;
   int                      grants_pending;

   // Stimulus state
   logic [ID_W-1:0]   cur_ids [NUM_SINGLE];
   logic [TICK_W-1:0] tick_now;
   logic              idle_enable;

   sound_voice_allocator u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_sound_id   (req_sound_id),
      .req_volume     (req_volume),
      .req_separation (req_separation),
      .req_now_tick   (req_now_tick),
      .rsp_valid      (rsp_valid),
      .rsp_voice      (rsp_voice),
      .rsp_handle     (rsp_handle),
      .rsp_mix_volume (rsp_mix_volume),
      .rsp_mix_pan    (rsp_mix_pan),
      .rsp_stolen     (rsp_stolen),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   sound_voice_allocator_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_sound_id   (req_sound_id),
      .req_volume     (req_volume),
      .req_separation (req_separation),
      .req_now_tick   (req_now_tick),
      .rsp_valid      (rsp_valid),
      .rsp_voice      (rsp_voice),
      .rsp_handle     (rsp_handle),
      .rsp_mix_volume (rsp_mix_volume),
      .rsp_mix_pan    (rsp_mix_pan),
      .rsp_stolen     (rsp_stolen),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .grants_pending (grants_pending)
   );

   // Clock
   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // Hard stop on a hung run
   initial begin
      #(TIMEOUT_NS);
      $display("FAIL");
      $finish;
   end

   // Present one request and hold it until the transfer
   task automatic send_start(input logic [ID_W-1:0]   id,
                             input logic [VOL_W-1:0]  vol,
                             input logic [SEP_W-1:0]  sep,
                             input logic [TICK_W-1:0] tick);
      while (idle_enable && $urandom_range(99) < IDLE_PCT) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_sound_id   <= id;
      req_volume     <= vol;
      req_separation <= sep;
      req_now_tick   <= tick;
      do @(posedge clock); while (busy);
   endtask

   // Drop start and wait until every grant has come back
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (grants_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register transfer: setup, access, then a quiet gap with select low
   task automatic reg_access(input csr_index_type idx, input logic wr,
                             input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= CSR_ADDR_W'(int'(idx) * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (wr && int'(idx) < NUM_SINGLE) cur_ids[idx] = value[ID_W-1:0];
   endtask

   // Write all six single-instance ids, then read them back
   task automatic program_ids(input logic [ID_W-1:0] ids [NUM_SINGLE]);
      for (int k = 0; k < NUM_SINGLE; k++)
         reg_access(csr_index_type'(k), 1'b1, CSR_DATA_W'(ids[k]));
      for (int k = 0; k < NUM_SINGLE; k++)
         reg_access(csr_index_type'(k), 1'b0, '0);
   endtask

   // Random request biased toward single-instance ids, few ids and close ticks
   task automatic random_start();
      logic [ID_W-1:0]  id;
      logic [VOL_W-1:0] vol;
      logic [SEP_W-1:0] sep;
      int               r;

      r = $urandom_range(99);
      if (r < 35)      id = cur_ids[$urandom_range(NUM_SINGLE - 1)];
      else if (r < 70) id = ID_W'($urandom_range(15));
      else             id = ID_W'($urandom_range(255));

      case ($urandom_range(19))
         0:       vol = '0;
         1:       vol = 7'd16;
         2:       vol = VOL_CLAMP_MIN;
         3:       vol = '1;
         default: vol = VOL_W'($urandom_range(127));
      endcase

      case ($urandom_range(19))
         0:       sep = '0;
         1:       sep = 8'd127;
         2:       sep = 8'd128;
         3:       sep = 8'd129;
         4:       sep = '1;
         default: sep = SEP_W'($urandom_range(255));
      endcase

      // Mostly advance time; zero steps give ties, jumps back can leave no older voice
      r = $urandom_range(99);
      if (r < 80)      tick_now = tick_now + $urandom_range(3);
      else if (r < 90) tick_now = $urandom;
      else if (r < 95) tick_now = tick_now - $urandom_range(20);
      else if (r < 98) tick_now = '0;
      else             tick_now = '1;

      send_start(id, vol, sep, tick_now);
   endtask

   // Stimulus
   initial begin
      logic [ID_W-1:0] ids [NUM_SINGLE];

      for (int k = 0; k < NUM_SINGLE; k++) cur_ids[k] = SINGLE_RESET[k];
      tick_now    = '0;
      idle_enable = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, fill, steal, tie, no older voice, single-instance reuse
      send_start(8'd10, 7'd0, 8'd0, 32'd100);
      send_start(8'd10, 7'd16, 8'd255, 32'd101);
      send_start(8'd5, VOL_CLAMP_MIN, 8'd128, 32'd102);
      send_start(8'd0, 7'd127, 8'd127, 32'd103);
      send_start(8'd255, 7'd1, 8'd129, 32'd50);
      send_start(8'd2, 7'd64, 8'd1, 32'd200);
      send_start(8'd3, 7'd32, 8'd254, 32'd50);
      send_start(8'd4, 7'd127, 8'd64, 32'd0);
      send_start(8'd6, 7'd100, 8'd192, 32'hFFFF_FFFF);
      send_start(8'd7, 7'd5, 8'd130, 32'd300);
      send_start(8'd8, 7'd6, 8'd126, 32'd0);
      send_start(8'd11, 7'd7, 8'd2, 32'd400);
      send_start(8'd11, 7'd8, 8'd253, 32'd401);
      send_start(8'd1, 7'd9, 8'd100, 32'hFFFF_FFFF);
      send_start(8'd200, 7'd10, 8'd160, 32'hFFFF_FFFF);
      wait_idle();
      reg_access(REG_SINGLE_A, 1'b1, 32'd0);
      reg_access(REG_SPARE_6, 1'b1, 32'd200);
      reg_access(REG_SPARE_7, 1'b1, 32'd255);
      reg_access(REG_SINGLE_A, 1'b0, '0);
      send_start(8'd0, 7'd127, 8'd255, 32'd500);
      send_start(8'd0, 7'd0, 8'd0, 32'd501);
      send_start(8'd200, 7'd3, 8'd128, 32'd502);
      send_start(8'd200, 7'd4, 8'd128, 32'd502);
      wait_idle();

      // Random phases, each under its own id setting
      for (int p = 0; p < PHASES; p++) begin
         for (int k = 0; k < NUM_SINGLE; k++) begin
            case (p)
               0:       ids[k] = '0;
               1:       ids[k] = '1;
               2:       ids[k] = ID_W'($urandom_range(255));
               3:       ids[k] = ID_W'($urandom_range(15));
               default: ids[k] = SINGLE_RESET[k];
            endcase
         end
         program_ids(ids);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // one long stretch at full rate
            idle_enable = !(p == 2 && n >= 50 && n < 300);
            random_start();
         end
         wait_idle();
      end

      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
